// ===== rtl/jts_pkg.sv =====
package jts_pkg;

   // Default width of the line counter.
   localparam int LINE_BITS_DEFAULT = 16;

   // Result queue geometry: room for two items per accepted byte.
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   // Characters with a meaning of their own.
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_E         = 8'h65;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_L         = 8'h6C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_S         = 8'h73;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   // Keyword selection codes.
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_STRING = 3'd1,
      MODE_ESCAPE = 3'd2,
      MODE_NUMBER = 3'd3,
      MODE_KEYWORD = 3'd4,
      MODE_ERROR  = 3'd5,
      MODE_ENDED  = 3'd6
   } scan_mode_type;

   typedef enum logic [3:0] {
      TK_OBJ_BEGIN = 4'd0,
      TK_OBJ_END   = 4'd1,
      TK_ARR_BEGIN = 4'd2,
      TK_ARR_END   = 4'd3,
      TK_STR_CHAR  = 4'd4,
      TK_STR_END   = 4'd5,
      TK_NUM_CHAR  = 4'd6,
      TK_NUM_END   = 4'd7,
      TK_TRUE      = 4'd8,
      TK_FALSE     = 4'd9,
      TK_NULL      = 4'd10,
      TK_COMMA     = 4'd11,
      TK_COLON     = 4'd12,
      TK_COMMENT   = 4'd13,
      TK_EOF       = 4'd14,
      TK_ERROR     = 4'd15
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_UNEXP_END  = 2'd1,
      ERR_UNEXP_CHAR = 2'd2,
      ERR_KEYWORD    = 2'd3
   } error_code_type;

   // One result item as it sits in the queue.
   typedef struct packed {
      token_kind_type token_kind;
      logic [7:0]     payload;
      error_code_type error_code;
      logic [15:0]    line_number;
      logic           last_result;
   } rsp_item_type;

   // Up to two result items pushed for one accepted byte.
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

   // Expected keyword character at a given position.
   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
      logic [7:0] ch;
      ch = CH_NUL;
      unique case (sel)
         KW_TRUE: begin
            case (idx)
               3'd0: ch = CH_T;
               3'd1: ch = CH_R;
               3'd2: ch = CH_U;
               3'd3: ch = CH_E;
               default: ch = CH_NUL;
            endcase
         end
         KW_FALSE: begin
            case (idx)
               3'd0: ch = CH_F;
               3'd1: ch = CH_A;
               3'd2: ch = CH_L;
               3'd3: ch = CH_S;
               3'd4: ch = CH_E;
               default: ch = CH_NUL;
            endcase
         end
         KW_NULL: begin
            case (idx)
               3'd0: ch = CH_N;
               3'd1: ch = CH_U;
               3'd2: ch = CH_L;
               3'd3: ch = CH_L;
               default: ch = CH_NUL;
            endcase
         end
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   // Keyword length; an unused selection has length zero and never matches.
   function automatic logic [2:0] kw_len(input logic [1:0] sel);
      logic [2:0] len;
      unique case (sel)
         KW_TRUE:  len = 3'd4;
         KW_FALSE: len = 3'd5;
         KW_NULL:  len = 3'd4;
         default:  len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic token_kind_type kw_kind(input logic [1:0] sel);
      token_kind_type kind;
      unique case (sel)
         KW_TRUE:  kind = TK_TRUE;
         KW_FALSE: kind = TK_FALSE;
         default:  kind = TK_NULL;
      endcase
      return kind;
   endfunction

endpackage

// ===== rtl/jts_rsp_fifo.sv =====
module jts_rsp_fifo
   import jts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rsp_push_type   push,
   output logic           room,
   output rsp_item_type   head,
   output logic           head_valid,
   input  logic           head_stall
);

   rsp_item_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0]   count_ff, count_in;
   logic [RSP_PTR_BITS-1:0]   wr_ptr_next;
   logic                      pop;
   logic [RSP_CNT_BITS-1:0]   push_n;

   // A new byte may enter only while two entries are free.
   assign room       = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid & ~head_stall;

   // Pointer and fill count updates.
   always_comb begin
      push_n      = RSP_CNT_BITS'(push.first_valid) + RSP_CNT_BITS'(push.second_valid);
      wr_ptr_next = wr_ptr_ff + RSP_PTR_BITS'(1);
      wr_ptr_in   = wr_ptr_ff + RSP_PTR_BITS'(push_n);
      rd_ptr_in   = rd_ptr_ff + RSP_PTR_BITS'(pop);
      count_in    = count_ff + push_n - RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the second item always follows the first.
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

// ===== rtl/json_token_scanner.sv =====
// Streaming JSON token scanner.
// The req channel carries one byte of text per item (req_data_byte), or the
// end of the text (req_end_of_input, or a zero byte). The rsp channel carries
// token items: kind, character payload, error code, current line number and
// a flag on the last item caused by each byte. A byte gives zero, one or two
// items; two only when a number is closed by a comma or a closing brace.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// Throughput is one byte per cycle while req_stall is low: the scanner state
// is updated in the cycle a byte is accepted, and its items are written into
// a four-entry result queue, from which they show on rsp in order.
// req_stall rises when fewer than two queue entries are free, so a stall on
// rsp holds the head item steady and backs up into req after at most two
// more bytes that give items.
// Synchronous reset empties the queue and returns the scanner to idle with
// line one. After an error, every later byte gives one error item with the
// stored code; after the end of text, every later byte gives one eof item.
module json_token_scanner
   import jts_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [7:0]  rsp_payload,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_result
);

   scan_mode_type         mode_ff, mode_in;
   logic [1:0]            select_ff, select_in;
   logic [2:0]            index_ff, index_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic                  cr_ff, cr_in;
   logic                  started_ff, started_in;
   error_code_type        err_ff, err_in;

   logic                  accept;
   logic                  room;
   logic [7:0]            c;
   logic                  at_end;
   logic                  is_ws;
   logic                  is_digit;
   logic                  in_token;
   logic                  kw_hit;
   logic                  kw_done;
   logic [31:0]           line_wide;
   logic [15:0]           line_shown;
   rsp_push_type          push;
   rsp_item_type          head;
   token_kind_type        kind0, kind1;
   logic [7:0]            pay0;
   logic                  has0, has1;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = ~room;

   // Byte classification.
   always_comb begin
      c        = req_data_byte;
      at_end   = req_end_of_input | (c == CH_NUL);
      is_ws    = (c == CH_SPACE) | (c == CH_TAB) | (c == CH_LF) | (c == CH_CR);
      is_digit = (c >= CH_ZERO) & (c <= CH_NINE);
      in_token = (mode_ff == MODE_STRING) | (mode_ff == MODE_ESCAPE) |
                 (mode_ff == MODE_NUMBER) | (mode_ff == MODE_KEYWORD);
      kw_hit   = (index_ff < kw_len(select_ff)) & (c == kw_char(select_ff, index_ff));
      kw_done  = ((index_ff + 3'd1) == kw_len(select_ff));
   end

   // Next scanner state for the byte on req.
   always_comb begin
      logic do_track;
      do_track   = 1'b0;
      mode_in    = mode_ff;
      select_in  = select_ff;
      index_in   = index_ff;
      line_in    = line_ff;
      cr_in      = cr_ff;
      started_in = started_ff;
      err_in     = err_ff;
      if ((mode_ff == MODE_ENDED) || (mode_ff == MODE_ERROR)) begin
         mode_in = mode_ff;
      end else if (at_end) begin
         if (in_token) begin
            mode_in = MODE_ERROR;
            err_in  = ERR_UNEXP_END;
         end else begin
            mode_in = MODE_ENDED;
         end
      end else begin
         unique case (mode_ff)
            MODE_STRING: begin
               do_track = 1'b1;
               if (c == CH_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else if (c == CH_QUOTE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_ESCAPE: begin
               do_track = 1'b1;
               mode_in  = MODE_STRING;
            end
            MODE_NUMBER: begin
               if (is_digit || (c == CH_DOT) || ((c == CH_MINUS) && !started_ff)) begin
                  cr_in      = 1'b0;
                  started_in = 1'b1;
               end else if ((c == CH_COMMA) || (c == CH_RBRACE) || is_ws) begin
                  do_track   = 1'b1;
                  mode_in    = MODE_IDLE;
                  started_in = 1'b0;
               end else begin
                  cr_in   = 1'b0;
                  mode_in = MODE_ERROR;
                  err_in  = ERR_UNEXP_CHAR;
               end
            end
            MODE_KEYWORD: begin
               cr_in = 1'b0;
               if (kw_hit) begin
                  if (kw_done) begin
                     mode_in  = MODE_IDLE;
                     index_in = '0;
                  end else begin
                     index_in = index_ff + 3'd1;
                  end
               end else begin
                  mode_in = MODE_ERROR;
                  err_in  = ERR_KEYWORD;
               end
            end
            default: begin
               // Idle between tokens.
               mode_in  = MODE_IDLE;
               do_track = 1'b1;
               if (!is_ws) begin
                  case (c) inside
                     CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
                     CH_COMMA, CH_COLON, CH_SLASH: begin
                        mode_in = MODE_IDLE;
                     end
                     CH_QUOTE: begin
                        mode_in = MODE_STRING;
                     end
                     CH_T, CH_F, CH_N: begin
                        select_in = (c == CH_T) ? KW_TRUE : (c == CH_F) ? KW_FALSE : KW_NULL;
                        index_in  = 3'd1;
                        mode_in   = MODE_KEYWORD;
                     end
                     CH_MINUS, [CH_ZERO:CH_NINE]: begin
                        mode_in    = MODE_NUMBER;
                        started_in = 1'b1;
                     end
                     default: begin
                        mode_in = MODE_ERROR;
                        err_in  = ERR_UNEXP_CHAR;
                     end
                  endcase
               end
            end
         endcase
      end
      // Line tracking: CR counts, LF counts unless it follows a CR.
      if (do_track) begin
         if (c == CH_CR) begin
            if (line_ff != '1) begin
               line_in = line_ff + LINE_BITS'(1);
            end
            cr_in = 1'b1;
         end else begin
            if ((c == CH_LF) && !cr_ff && (line_ff != '1)) begin
               line_in = line_ff + LINE_BITS'(1);
            end
            cr_in = 1'b0;
         end
      end
   end

   // Result items for the byte on req.
   always_comb begin
      has0  = 1'b0;
      has1  = 1'b0;
      kind0 = TK_EOF;
      kind1 = TK_EOF;
      pay0  = '0;
      if (mode_ff == MODE_ENDED) begin
         has0  = 1'b1;
         kind0 = TK_EOF;
      end else if (mode_ff == MODE_ERROR) begin
         has0  = 1'b1;
         kind0 = TK_ERROR;
      end else if (at_end) begin
         has0  = 1'b1;
         kind0 = in_token ? TK_ERROR : TK_EOF;
      end else begin
         unique case (mode_ff)
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  has0  = 1'b1;
                  kind0 = TK_STR_END;
               end else if (c != CH_BACKSLASH) begin
                  has0  = 1'b1;
                  kind0 = TK_STR_CHAR;
                  pay0  = c;
               end
            end
            MODE_ESCAPE: begin
               has0  = 1'b1;
               kind0 = TK_STR_CHAR;
               pay0  = c;
            end
            MODE_NUMBER: begin
               has0 = 1'b1;
               if (is_digit || (c == CH_DOT) || ((c == CH_MINUS) && !started_ff)) begin
                  kind0 = TK_NUM_CHAR;
                  pay0  = c;
               end else if (c == CH_COMMA) begin
                  kind0 = TK_NUM_END;
                  has1  = 1'b1;
                  kind1 = TK_COMMA;
               end else if (c == CH_RBRACE) begin
                  kind0 = TK_NUM_END;
                  has1  = 1'b1;
                  kind1 = TK_OBJ_END;
               end else if (is_ws) begin
                  kind0 = TK_NUM_END;
               end else begin
                  kind0 = TK_ERROR;
               end
            end
            MODE_KEYWORD: begin
               if (!kw_hit) begin
                  has0  = 1'b1;
                  kind0 = TK_ERROR;
               end else if (kw_done) begin
                  has0  = 1'b1;
                  kind0 = kw_kind(select_ff);
               end
            end
            default: begin
               if (!is_ws) begin
                  has0 = 1'b1;
                  case (c) inside
                     CH_LBRACE:   kind0 = TK_OBJ_BEGIN;
                     CH_RBRACE:   kind0 = TK_OBJ_END;
                     CH_LBRACKET: kind0 = TK_ARR_BEGIN;
                     CH_RBRACKET: kind0 = TK_ARR_END;
                     CH_COMMA:    kind0 = TK_COMMA;
                     CH_COLON:    kind0 = TK_COLON;
                     CH_SLASH:    kind0 = TK_COMMENT;
                     CH_QUOTE, CH_T, CH_F, CH_N: begin
                        has0 = 1'b0;
                     end
                     CH_MINUS, [CH_ZERO:CH_NINE]: begin
                        kind0 = TK_NUM_CHAR;
                        pay0  = c;
                     end
                     default:     kind0 = TK_ERROR;
                  endcase
               end
            end
         endcase
      end
   end

   // Line number as shown on rsp, held at its top value.
   always_comb begin
      line_wide  = 32'(line_in);
      line_shown = (line_wide > 32'h0000_FFFF) ? 16'hFFFF : line_wide[15:0];
   end

   // Items pushed into the result queue.
   always_comb begin
      push.first_valid        = accept & has0;
      push.second_valid       = accept & has1;
      push.first.token_kind   = kind0;
      push.first.payload      = pay0;
      push.first.error_code   = (kind0 == TK_ERROR) ? err_in : ERR_NONE;
      push.first.line_number  = line_shown;
      push.first.last_result  = ~has1;
      push.second.token_kind  = kind1;
      push.second.payload     = '0;
      push.second.error_code  = ERR_NONE;
      push.second.line_number = line_shown;
      push.second.last_result = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         select_ff  <= KW_TRUE;
         index_ff   <= '0;
         line_ff    <= LINE_BITS'(1);
         cr_ff      <= 1'b0;
         started_ff <= 1'b0;
         err_ff     <= ERR_NONE;
      end else if (accept) begin
         mode_ff    <= mode_in;
         select_ff  <= select_in;
         index_ff   <= index_in;
         line_ff    <= line_in;
         cr_ff      <= cr_in;
         started_ff <= started_in;
         err_ff     <= err_in;
      end
   end

   jts_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head       (head),
      .head_valid (rsp_valid),
      .head_stall (rsp_stall)
   );

   assign rsp_token_kind  = head.token_kind;
   assign rsp_payload     = head.payload;
   assign rsp_error_code  = head.error_code;
   assign rsp_line_number = head.line_number;
   assign rsp_last_result = head.last_result;

endmodule

// ===== rtl/jts_checker.sv =====
module jts_checker
   import jts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_token_kind,
   input logic [7:0]  rsp_payload,
   input logic [1:0]  rsp_error_code,
   input logic [15:0] rsp_line_number,
   input logic        rsp_last_result
);

   logic err_seen_ff;

   // Remembers that an error item has been delivered since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && (rsp_token_kind == TK_ERROR)) begin
         err_seen_ff <= 1'b1;
      end
   end

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_payload) && $stable(rsp_error_code) &&
      $stable(rsp_line_number) && $stable(rsp_last_result))
      else $error("rsp item changed while stalled");

   // Errors are sticky: after one error item only error items follow.
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |-> rsp_token_kind == TK_ERROR)
      else $error("non-error item after an error item");

   // An error code is present exactly on error items.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_token_kind == TK_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match token kind");

   // Only character kinds carry a payload.
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != TK_STR_CHAR) && (rsp_token_kind != TK_NUM_CHAR)
      |-> rsp_payload == 8'h00)
      else $error("payload on a non-character item");

endmodule

bind json_token_scanner jts_checker u_jts_checker (.*);

// ===== bench/tb_json_token_scanner.sv =====
`timescale 1ns / 100ps

module tb_json_token_scanner;
   import jts_pkg::*;

   // Tracks the scanner state and holds the token items that each accepted byte should yield.
   class json_token_predictor;
      scan_mode_type  mode;
      logic [1:0]     kw_sel;
      logic [2:0]     kw_pos;
      logic [15:0]    lines;
      logic           after_cr;
      logic           in_number;
      error_code_type saved_err;
      rsp_item_type   pending_tokens[$];
      int             mismatches;
      string          kw_text[3];

      function new();
         kw_text    = '{"true", "false", "null"};
         mode       = MODE_IDLE;
         kw_sel     = KW_TRUE;
         kw_pos     = 3'd0;
         lines      = 16'd1;
         after_cr   = 1'b0;
         in_number  = 1'b0;
         saved_err  = ERR_NONE;
         mismatches = 0;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      // A CR starts a new line and a LF does so unless it completes a CRLF pair; the count stops at its top value.
      function void track(logic [7:0] c);
         if (c == CH_CR) begin
            if (lines != 16'hFFFF) lines++;
            after_cr = 1'b1;
         end else if (c == CH_LF) begin
            if (!after_cr && lines != 16'hFFFF) lines++;
            after_cr = 1'b0;
         end else begin
            after_cr = 1'b0;
         end
      endfunction

      function void push_token(token_kind_type kind, logic [7:0] ch);
         rsp_item_type t;
         t.token_kind  = kind;
         t.payload     = ch;
         t.error_code  = (kind == TK_ERROR) ? saved_err : ERR_NONE;
         t.line_number = lines;
         t.last_result = 1'b0;
         pending_tokens.push_back(t);
      endfunction

      function void raise_error(error_code_type code);
         saved_err = code;
         mode      = MODE_ERROR;
         push_token(TK_ERROR, 8'h00);
      endfunction

      // Punctuation and the first byte of a string, keyword or number, seen between tokens.
      function void idle_start(logic [7:0] c);
         case (c)
            CH_LBRACE: push_token(TK_OBJ_BEGIN, 8'h00);
            CH_RBRACE: push_token(TK_OBJ_END, 8'h00);
            CH_LBRACKET: push_token(TK_ARR_BEGIN, 8'h00);
            CH_RBRACKET: push_token(TK_ARR_END, 8'h00);
            CH_COMMA: push_token(TK_COMMA, 8'h00);
            CH_COLON: push_token(TK_COLON, 8'h00);
            CH_SLASH: push_token(TK_COMMENT, 8'h00);
            CH_QUOTE: mode = MODE_STRING;
            CH_T, CH_F, CH_N: begin
               kw_sel = (c == CH_T) ? KW_TRUE : (c == CH_F) ? KW_FALSE : KW_NULL;
               kw_pos = 3'd1;
               mode   = MODE_KEYWORD;
            end
            default: begin
               if (c == CH_MINUS || is_digit(c)) begin
                  mode      = MODE_NUMBER;
                  in_number = 1'b1;
                  push_token(TK_NUM_CHAR, c);
               end else begin
                  raise_error(ERR_UNEXP_CHAR);
               end
            end
         endcase
      endfunction

      // Called for every byte the scanner accepts.
      function void note_byte(logic [7:0] c, logic eoi);
         int size_at_start;
         size_at_start = pending_tokens.size();
         if (mode == MODE_ENDED) begin
            push_token(TK_EOF, 8'h00);
         end else if (mode == MODE_ERROR) begin
            push_token(TK_ERROR, 8'h00);
         end else if (eoi || c == CH_NUL) begin
            if (mode == MODE_IDLE) begin
               mode = MODE_ENDED;
               push_token(TK_EOF, 8'h00);
            end else begin
               raise_error(ERR_UNEXP_END);
            end
         end else if (mode == MODE_STRING) begin
            track(c);
            if (c == CH_BACKSLASH) begin
               mode = MODE_ESCAPE;
            end else if (c == CH_QUOTE) begin
               mode = MODE_IDLE;
               push_token(TK_STR_END, 8'h00);
            end else begin
               push_token(TK_STR_CHAR, c);
            end
         end else if (mode == MODE_ESCAPE) begin
            track(c);
            mode = MODE_STRING;
            push_token(TK_STR_CHAR, c);
         end else if (mode == MODE_NUMBER) begin
            if (c == CH_DOT || is_digit(c) || (c == CH_MINUS && !in_number)) begin
               after_cr  = 1'b0;
               in_number = 1'b1;
               push_token(TK_NUM_CHAR, c);
            end else if (c == CH_COMMA || c == CH_RBRACE || is_blank(c)) begin
               // The closing comma or brace also counts as a token of its own.
               track(c);
               mode      = MODE_IDLE;
               in_number = 1'b0;
               push_token(TK_NUM_END, 8'h00);
               if (!is_blank(c)) idle_start(c);
            end else begin
               after_cr = 1'b0;
               raise_error(ERR_UNEXP_CHAR);
            end
         end else if (mode == MODE_KEYWORD) begin
            after_cr = 1'b0;
            if (kw_pos < kw_text[kw_sel].len() && c == kw_text[kw_sel][kw_pos]) begin
               kw_pos = kw_pos + 3'd1;
               if (kw_pos == kw_text[kw_sel].len()) begin
                  mode   = MODE_IDLE;
                  kw_pos = 3'd0;
                  push_token((kw_sel == KW_TRUE) ? TK_TRUE :
                             (kw_sel == KW_FALSE) ? TK_FALSE : TK_NULL, 8'h00);
               end
            end else begin
               raise_error(ERR_KEYWORD);
            end
         end else begin
            mode = MODE_IDLE;
            track(c);
            if (!is_blank(c)) idle_start(c);
         end
         if (pending_tokens.size() > size_at_start)
            pending_tokens[pending_tokens.size() - 1].last_result = 1'b1;
      endfunction

      // Compares one accepted token item with the oldest one still expected.
      function void check_token(rsp_item_type got);
         rsp_item_type want;
         if (pending_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: kind %0d payload %02h err %0d line %0d last %0b",
                        got.token_kind, got.payload, got.error_code, got.line_number,
                        got.last_result);
            return;
         end
         want = pending_tokens.pop_front();
         if (got.token_kind !== want.token_kind || got.payload !== want.payload ||
             got.error_code !== want.error_code || got.line_number !== want.line_number ||
             got.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("item mismatch: expected kind %0d payload %02h err %0d line %0d last %0b",
                        want.token_kind, want.payload, want.error_code, want.line_number,
                        want.last_result);
               $display("               got kind %0d payload %02h err %0d line %0d last %0b",
                        got.token_kind, got.payload, got.error_code, got.line_number,
                        got.last_result);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [7:0]  rsp_payload;
   logic [1:0]  rsp_error_code;
   logic [15:0] rsp_line_number;
   logic        rsp_last_result;

   json_token_predictor tokenizer = new();
   int unsigned send_idle_pct = 23;
   int unsigned recv_idle_pct = 57;
   bit          hold_request = 1'b0;
   int          bytes_sent = 0;

   json_token_scanner u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_payload     (rsp_payload),
      .rsp_error_code  (rsp_error_code),
      .rsp_line_number (rsp_line_number),
      .rsp_last_result (rsp_last_result)
   );

   initial forever #2 clock = ~clock;

   // Offers one byte, with random idle cycles first, and waits until it is taken.
   task automatic put_byte(input logic [7:0] c, input logic eoi = 1'b0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      tokenizer.note_byte(c, eoi);
      bytes_sent++;
   endtask

   // One well-formed piece of JSON text with random content.
   task automatic put_fragment();
      int         pick;
      int         word;
      logic [7:0] c;
      logic [7:0] marks[7];
      marks = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COMMA, CH_COLON, CH_SLASH};
      pick = $urandom_range(99);
      if (pick < 25) begin
         put_byte(CH_QUOTE);
         repeat ($urandom_range(6)) begin
            if ($urandom_range(5) == 0) begin
               put_byte(CH_BACKSLASH);
               put_byte(8'($urandom_range(255, 1)));
            end else begin
               c = 8'($urandom_range(255, 1));
               if (c == CH_QUOTE || c == CH_BACKSLASH) c = CH_SPACE;
               put_byte(c);
            end
         end
         put_byte(CH_QUOTE);
      end else if (pick < 50) begin
         if ($urandom_range(3) == 0) put_byte(CH_MINUS);
         else put_byte(CH_ZERO + 8'($urandom_range(9)));
         repeat ($urandom_range(5)) begin
            if ($urandom_range(5) == 0) put_byte(CH_DOT);
            else put_byte(CH_ZERO + 8'($urandom_range(9)));
         end
         // A number only closes on a comma, a closing brace or whitespace.
         case ($urandom_range(5))
            0: put_byte(CH_COMMA);
            1: put_byte(CH_RBRACE);
            2: put_byte(CH_SPACE);
            3: put_byte(CH_TAB);
            4: put_byte(CH_CR);
            default: put_byte(CH_LF);
         endcase
      end else if (pick < 62) begin
         word = $urandom_range(2);
         for (int i = 0; i < tokenizer.kw_text[word].len(); i++)
            put_byte(tokenizer.kw_text[word][i]);
      end else if (pick < 85) begin
         put_byte(marks[$urandom_range(6)]);
      end else begin
         case ($urandom_range(4))
            0: put_byte(CH_SPACE);
            1: put_byte(CH_TAB);
            2: put_byte(CH_CR);
            3: put_byte(CH_LF);
            default: begin
               put_byte(CH_CR);
               put_byte(CH_LF);
            end
         endcase
      end
   endtask

   // Result side: checks accepted items and stalls at random or for a long hold-off.
   initial begin : rsp_side
      int           hold_left;
      rsp_item_type got;
      hold_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.token_kind  = token_kind_type'(rsp_token_kind);
            got.payload     = rsp_payload;
            got.error_code  = error_code_type'(rsp_error_code);
            got.line_number = rsp_line_number;
            got.last_result = rsp_last_result;
            tokenizer.check_token(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] opening[$];
      int         drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // An escape, CRLF inside a string, number ends of every sort, a keyword and a comment.
      opening = '{CH_LBRACE, CH_QUOTE, 8'hFF, CH_BACKSLASH, CH_QUOTE, CH_CR, CH_LF, CH_QUOTE,
                  CH_COLON, CH_MINUS, CH_ZERO, CH_DOT, CH_NINE, CH_RBRACE, CH_LBRACKET,
                  8'h31, CH_COMMA, 8'h32, CH_TAB, CH_N, CH_U, CH_L, CH_L, CH_SLASH,
                  CH_RBRACKET};
      foreach (opening[i]) put_byte(opening[i]);

      // Random text with the sender idling less than the receiver.
      while (bytes_sent < 360) put_fragment();

      // The same with the idle rates swapped.
      send_idle_pct = 57;
      recv_idle_pct = 23;
      while (bytes_sent < 700) put_fragment();

      // No idling; a long hold-off on the result side backs up into the byte side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      while (bytes_sent < 900) put_fragment();
      repeat (40) put_fragment();

      // End the text in one of its terminal ways; both modes stay until reset.
      case ($urandom_range(9))
         0: put_byte(8'($urandom), 1'b1);
         1: put_byte(CH_NUL);
         2: begin
            put_byte(CH_QUOTE);
            put_byte(8'h41);
            put_byte(8'($urandom), 1'b1);
         end
         3: begin
            put_byte(CH_QUOTE);
            put_byte(CH_BACKSLASH);
            put_byte(CH_NUL);
         end
         4: begin
            put_byte(CH_NINE);
            put_byte(8'($urandom), 1'b1);
         end
         5: begin
            put_byte(CH_T);
            put_byte(CH_R);
            put_byte(CH_NUL);
         end
         6: begin
            put_byte(CH_F);
            put_byte(CH_A);
            put_byte(CH_E);
         end
         7: begin
            put_byte(CH_ZERO);
            put_byte(CH_MINUS);
         end
         8: begin
            put_byte(CH_ZERO);
            put_byte(8'h78);
         end
         default: put_byte(8'($urandom_range(255, 128)));
      endcase
      repeat (40) put_byte(8'($urandom), 1'($urandom_range(1)));
      req_valid <= 1'b0;

      drain = 0;
      while (tokenizer.pending_tokens.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (tokenizer.mismatches == 0 && tokenizer.pending_tokens.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
